/* src/etcs_pkg.sv */
// Package for the elapsed time counter with seek.
// Holds the transaction payload types, register indexes and time constants.
// No dependencies.
`default_nettype none

package etcs_pkg;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 1;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_JUMP_SECONDS     = 1'b0,
		CFG_TICKS_PER_SECOND = 1'b1
	} cfg_idx_t;

	// Field widths.
	localparam int unsigned MinW   = 6;
	localparam int unsigned SecW   = 6;
	localparam int unsigned TickW  = 10;
	localparam int unsigned JumpW  = 6;
	localparam int unsigned CfgW   = 10;

	// Time constants.
	localparam logic [SecW-1:0]  SecPerMin    = 6'd60;
	localparam logic [MinW-1:0]  MinPerHour   = 6'd60;
	localparam logic [JumpW-1:0] MaxJump      = 6'd59;
	localparam logic [JumpW-1:0] JumpReset    = 6'd10;
	localparam logic [TickW-1:0] TpsReset     = 10'd100;

	// One input transaction: a period tick with its mode and request flags.
	typedef struct packed {
		logic running;
		logic playing;
		logic seek_forward;
		logic seek_back;
		logic clear_time;
	} in_t;

	// One result transaction: the time as it stood before the tick.
	typedef struct packed {
		logic [MinW-1:0]  shown_minutes;
		logic [SecW-1:0]  shown_seconds;
		logic [TickW-1:0] shown_ticks;
	} out_t;

endpackage

`default_nettype wire

/* src/elapsed_time_counter_with_seek_core.sv */
// Top level of the elapsed time counter with seek; uses etcs_pkg for types and constants.
// The path from input transaction to result passes the input register and then the result register.
// Throughput: one tick per cycle while out_stall is low; the input register lets a tick be taken while a
// result waits, and the time update is a few small adds and compares.
// Reset: arst_n clears both valid flags and the time to 0:00:00, and loads the
// registers with a jump of 10 seconds and 100 ticks per second.
`default_nettype none

module elapsed_time_counter_with_seek_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire etcs_pkg::in_t            in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output etcs_pkg::out_t                out_data,
	input  wire logic                     cfg_we,
	input  wire etcs_pkg::cfg_idx_t       cfg_index,
	input  wire logic [etcs_pkg::CfgW-1:0] cfg_wdata
);
	import etcs_pkg::*;

	logic             valid_s1;
	in_t              item_s1;
	logic             out_valid_q;
	out_t             out_q;
	logic             advance;
	logic [JumpW-1:0] jump_q;
	logic [TickW-1:0] tps_q;
	logic [MinW-1:0]  minute_q;
	logic [SecW-1:0]  second_q;
	logic [TickW-1:0] tick_q;
	logic [MinW-1:0]  minute_d;
	logic [SecW-1:0]  second_d;
	logic [TickW-1:0] tick_d;

	// The input stage moves on when the result register is empty or being drained.
	assign advance   = ~out_valid_q | ~out_stall;
	assign in_stall  = valid_s1 & ~advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q <= JumpReset;
			tps_q  <= TpsReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_JUMP_SECONDS:     jump_q <= cfg_wdata[JumpW-1:0];
				CFG_TICKS_PER_SECOND: tps_q  <= cfg_wdata[TickW-1:0];
				default:              jump_q <= jump_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Next time for the tick in the input register.
	always_comb begin
		logic [JumpW-1:0] jump;
		logic [TickW-1:0] tps;
		logic [TickW-1:0] tick;
		logic [SecW:0]    sec;
		logic [MinW-1:0]  mins;
		jump = (jump_q > MaxJump) ? MaxJump : jump_q;
		tps  = (tps_q == '0) ? TickW'(1) : tps_q;
		tick = tick_q + TickW'(1);
		sec  = {1'b0, second_q};
		mins = minute_q;

		// Forward seek with minute carry.
		if (item_s1.playing && item_s1.seek_forward) begin
			sec = sec + {1'b0, jump};
			if (sec >= {1'b0, SecPerMin}) begin
				sec  = sec - {1'b0, SecPerMin};
				mins = (mins == MinPerHour - MinW'(1)) ? '0 : mins + MinW'(1);
			end
		end

		// Rewind with minute borrow, clamped at the start.
		if (item_s1.playing && item_s1.seek_back) begin
			if (sec >= {1'b0, jump}) begin
				sec = sec - {1'b0, jump};
			end else if (mins == '0) begin
				sec = '0;
			end else begin
				mins = mins - MinW'(1);
				sec  = sec + {1'b0, SecPerMin} - {1'b0, jump};
			end
		end

		if (item_s1.clear_time) begin
			mins = '0;
			sec  = '0;
			tick = '0;
		end

		// A full second of ticks carries into seconds and minutes.
		if (tick >= tps) begin
			tick = '0;
			sec  = sec + (SecW+1)'(1);
			if (sec >= {1'b0, SecPerMin}) begin
				sec  = '0;
				mins = (mins == MinPerHour - MinW'(1)) ? '0 : mins + MinW'(1);
			end
		end

		if (item_s1.running) begin
			minute_d = mins;
			second_d = sec[SecW-1:0];
			tick_d   = tick;
		end else begin
			minute_d = minute_q;
			second_d = second_q;
			tick_d   = tick_q;
		end
	end

	// Time state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_q    <= '0;
			second_q    <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				minute_q <= minute_d;
				second_q <= second_d;
				tick_q   <= tick_d;
			end
		end
	end

	// Result register carries the time before the update.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.shown_minutes <= minute_q;
			out_q.shown_seconds <= second_q;
			out_q.shown_ticks   <= tick_q;
		end
	end

	// Minutes and seconds never leave their displayed range.
	a_minute_range: assert property (@(posedge clk) disable iff (!arst_n)
		minute_q < MinPerHour) else $error("minute count out of range");

	a_second_range: assert property (@(posedge clk) disable iff (!arst_n)
		second_q < SecPerMin) else $error("second count out of range");

	// A tick that leaves the input stage always lands in the result register.
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q) else $error("transaction lost");

	// A stopped tick leaves the time unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !item_s1.running |=>
		$stable(minute_q) && $stable(second_q) && $stable(tick_q))
		else $error("time moved while stopped");

	// Input stall is raised only with a held tick that cannot move on.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("spurious input stall");

endmodule

`default_nettype wire

/* sim/tb_elapsed_time_counter_with_seek_core.sv */
// Self-checking testbench for elapsed_time_counter_with_seek_core.
// Depends on etcs_pkg and the core; a scoreboard class predicts the shown time of every tick.
`timescale 1ns / 1ps

module tb_elapsed_time_counter_with_seek_core;
	import etcs_pkg::*;

	localparam int unsigned StuckLimit = 3000;
	localparam int unsigned TailCycles = 8;

	// Predicts the display time and holds the results still owed by the core.
	class display_time_scoreboard;
		bit [JumpW-1:0] jump_cfg;
		bit [TickW-1:0] tps_cfg;
		bit [MinW-1:0]  minute_now;
		bit [SecW-1:0]  second_now;
		bit [TickW-1:0] tick_now;
		out_t           due_display_q[$];
		int unsigned    errors;
		int unsigned    checked;

		function new();
			jump_cfg   = JumpReset;
			tps_cfg    = TpsReset;
			minute_now = '0;
			second_now = '0;
			tick_now   = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void carry_minute();
			if (minute_now >= MinPerHour - 1)
				minute_now = '0;
			else
				minute_now = minute_now + 1;
		endfunction

		// Queue the time as it stands, then apply one tick.
		function void note_tick(in_t t);
			out_t shown;
			int   jmp;
			int   tps;
			int   sec;
			shown.shown_minutes = minute_now;
			shown.shown_seconds = second_now;
			shown.shown_ticks   = tick_now;
			due_display_q.push_back(shown);
			if (!t.running)
				return;
			jmp = (jump_cfg > MaxJump) ? int'(MaxJump) : int'(jump_cfg);
			tps = (tps_cfg == 0) ? 1 : int'(tps_cfg);
			tick_now = tick_now + 1;
			// Forward seek, with a minute carry.
			if (t.playing && t.seek_forward) begin
				sec = int'(second_now) + jmp;
				if (sec >= int'(SecPerMin)) begin
					sec = sec - int'(SecPerMin);
					carry_minute();
				end
				second_now = sec[SecW-1:0];
			end
			// Rewind, borrowing a minute or stopping at the start.
			if (t.playing && t.seek_back) begin
				if (int'(second_now) >= jmp) begin
					sec = int'(second_now) - jmp;
				end else if (minute_now == 0) begin
					sec = 0;
				end else begin
					minute_now = minute_now - 1;
					sec = int'(SecPerMin) - (jmp - int'(second_now));
				end
				second_now = sec[SecW-1:0];
			end
			if (t.clear_time) begin
				minute_now = '0;
				second_now = '0;
				tick_now   = '0;
			end
			// A full second of ticks carries into seconds and minutes.
			if (int'(tick_now) >= tps) begin
				tick_now = '0;
				if (second_now >= SecPerMin - 1) begin
					second_now = '0;
					carry_minute();
				end else begin
					second_now = second_now + 1;
				end
			end
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_display(out_t got, realtime at);
			out_t want;
			if (due_display_q.size() == 0) begin
				$display("%0t: result %0d:%0d:%0d arrived with nothing expected", at,
					got.shown_minutes, got.shown_seconds, got.shown_ticks);
				errors++;
				return;
			end
			want = due_display_q.pop_front();
			checked++;
			if (got.shown_minutes !== want.shown_minutes) begin
				$display("%0t: shown_minutes expected %0d actual %0d", at,
					want.shown_minutes, got.shown_minutes);
				errors++;
			end
			if (got.shown_seconds !== want.shown_seconds) begin
				$display("%0t: shown_seconds expected %0d actual %0d", at,
					want.shown_seconds, got.shown_seconds);
				errors++;
			end
			if (got.shown_ticks !== want.shown_ticks) begin
				$display("%0t: shown_ticks expected %0d actual %0d", at,
					want.shown_ticks, got.shown_ticks);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return due_display_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	cfg_idx_t         cfg_index = CFG_JUMP_SECONDS;
	logic [CfgW-1:0]  cfg_wdata = '0;

	display_time_scoreboard sb;
	bit          calm = 1'b0;
	int unsigned stuck_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned ticks_sent = 0;
	int unsigned settings_used = 0;

	elapsed_time_counter_with_seek_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic in_t make_tick(bit run, bit play, bit fwd, bit back, bit clr);
		in_t t;
		t.running      = run;
		t.playing      = play;
		t.seek_forward = fwd;
		t.seek_back    = back;
		t.clear_time   = clr;
		return t;
	endfunction

	// Receiver side: random stall stretches; no new one starts while calm.
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!calm && arst_n && $urandom_range(0, 99) < 25)
			stall_left = pick_gap();
		out_stall <= (stall_left > 0);
	end

	// Transaction monitor on both channels, plus the watchdog.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_tick(in_data);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				sb.check_display(out_data, $realtime);
				moved = 1'b1;
			end
		end
		if (moved)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= StuckLimit) begin
			$display("%0t: no transaction for %0d cycles", $realtime, StuckLimit);
			$display("elapsed_time_counter_with_seek_core test failed");
			$finish;
		end
	end

	// Offer one tick after a random gap and hold it until it is taken.
	task automatic send_tick(in_t t);
		int unsigned gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		ticks_sent++;
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the jump register, then the ticks-per-second register, while the core is idle.
	task automatic apply_settings(bit [CfgW-1:0] jump, bit [CfgW-1:0] tps);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_JUMP_SECONDS;
		cfg_wdata <= jump;
		@(negedge clk);
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_wdata <= tps;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.jump_cfg = jump[JumpW-1:0];
		sb.tps_cfg  = tps[TickW-1:0];
		settings_used++;
	endtask

	// One setting followed by random ticks with the given request mix.
	task automatic run_phase(bit [CfgW-1:0] jump, bit [CfgW-1:0] tps, int unsigned count,
			int unsigned run_pct, int unsigned fwd_pct, int unsigned back_pct,
			int unsigned clr_pct, bit quiet);
		in_t t;
		drain_results();
		apply_settings(jump, tps);
		calm = quiet;
		repeat (count) begin
			t.running      = ($urandom_range(0, 99) < run_pct);
			t.playing      = ($urandom_range(0, 99) < 85);
			t.seek_forward = ($urandom_range(0, 99) < fwd_pct);
			t.seek_back    = ($urandom_range(0, 99) < back_pct);
			t.clear_time   = ($urandom_range(0, 999) < clr_pct * 10);
			send_tick(t);
		end
		calm = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks under the reset setting: jump 10, 100 ticks per second.
		send_tick(make_tick(0, 0, 0, 0, 0));
		send_tick(make_tick(0, 1, 1, 1, 1));   // stopped: every request ignored
		send_tick(make_tick(1, 0, 0, 0, 0));
		send_tick(make_tick(1, 1, 1, 0, 0));
		send_tick(make_tick(1, 0, 1, 0, 0));   // seek without playback is ignored
		send_tick(make_tick(1, 0, 0, 1, 0));
		send_tick(make_tick(1, 1, 0, 1, 0));
		send_tick(make_tick(1, 1, 0, 1, 0));   // rewind past the start clamps at zero
		repeat (6) send_tick(make_tick(1, 1, 1, 0, 0));   // forward into the next minute
		send_tick(make_tick(1, 1, 0, 1, 0));   // rewind borrows a minute
		send_tick(make_tick(1, 1, 1, 1, 0));   // both seeks in one tick
		send_tick(make_tick(1, 1, 1, 1, 1));   // clear wins over seeks
		send_tick(make_tick(1, 0, 0, 0, 1));
		send_tick(make_tick(0, 0, 0, 0, 1));   // clear while stopped is ignored
		send_tick(make_tick(1, 1, 1, 0, 0));
		send_tick(make_tick(1, 1, 0, 0, 0));

		// Random phases: hour wrap, deep tick counts, clamped jump, degenerate rates.
		run_phase(10'd59,   10'd1,    150, 95, 60, 10, 1, 1'b0);
		run_phase(10'd10,   10'd600,  700, 95, 10, 10, 0, 1'b0);
		run_phase(10'd0,    10'd3,    120, 90, 30, 30, 2, 1'b0);
		run_phase(10'd63,   10'd1023, 120, 90, 30, 30, 3, 1'b0);
		run_phase(10'd1,    10'd0,    120, 70, 30, 30, 3, 1'b1);
		run_phase(10'd30,   10'd1000, 150, 90, 20, 40, 3, 1'b0);
		run_phase(10'd45,   10'd7,    140, 50, 40, 40, 5, 1'b0);
		run_phase(10'd60,   10'd100,   60, 90, 40, 30, 2, 1'b0);

		// Wait out the owed results, then watch for strays.
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d ticks over %0d register settings; %0d results checked.",
			ticks_sent, settings_used, sb.checked);
		$display("Covered seeks, rewind clamp, hour wrap, clear, and rate changes mid-count.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("elapsed_time_counter_with_seek_core test passed");
		end else begin
			$display("elapsed_time_counter_with_seek_core test failed");
		end
		$finish;
	end

endmodule
